// ===== src/pfq_pkg.sv =====
// Shared types and constants of the power fault qualifier.
package pfq_pkg;

    // Tries of one sampling check; the try counter saturates at the 2-bit maximum.
    localparam int unsigned MAX_TRIES = 3;
    localparam logic [1:0]  MaxTriesCode = 2'(MAX_TRIES);
    localparam logic [1:0]  TryCountMax  = 2'd3;
    localparam logic [1:0]  OverCountMax = 2'd3;

    // Field widths.
    localparam int unsigned THRESH_W = 26;
    localparam int unsigned MA_W     = 16;
    localparam int unsigned DATA_W   = 26;

    // Scale factor from milliamps to microamps, and reset values of the registers.
    localparam logic [9:0]          MaToUa          = 10'd1000;
    localparam logic [THRESH_W-1:0] ThresholdReset  = 26'd1400000;
    localparam logic [1:0]          CountLimitReset = 2'd1;

    // Configuration register indexes.
    typedef enum logic
    {
        CFG_THRESHOLD   = 1'b0,
        CFG_COUNT_LIMIT = 1'b1
    } cfg_index_t;

    // Request kinds.
    typedef enum logic
    {
        KIND_EVENT  = 1'b0,
        KIND_SAMPLE = 1'b1
    } kind_t;

    // Verdict codes.
    typedef enum logic [2:0]
    {
        VERDICT_PENDING   = 3'd0,
        VERDICT_IGNORED   = 3'd1,
        VERDICT_TRANSIENT = 3'd2,
        VERDICT_TOO_FEW   = 3'd3,
        VERDICT_END_POWER = 3'd4
    } verdict_t;

    // Reasons for ending power.
    typedef enum logic [1:0]
    {
        REASON_NONE             = 2'd0,
        REASON_OVER_VOLTAGE     = 2'd1,
        REASON_OVER_TEMPERATURE = 2'd2,
        REASON_OVER_CURRENT     = 2'd3
    } reason_t;

    // One input request.
    typedef struct packed
    {
        kind_t           kind;
        logic            over_voltage;
        logic            over_temperature;
        logic            under_voltage;
        logic            over_current;
        logic            clear_ok;
        logic            current_ok;
        logic [MA_W-1:0] current_ma;
        logic            status_ok;
        logic            still_over;
    } item_t;

    // One result.
    typedef struct packed
    {
        verdict_t   verdict;
        reason_t    end_reason;
        logic [1:0] over_samples;
        logic [1:0] tries_used;
    } result_t;

    // Configuration values seen by the qualifier logic.
    typedef struct packed
    {
        logic [THRESH_W-1:0] threshold_ua;
        logic [1:0]          count_limit;
    } cfg_t;

endpackage

// ===== src/pfq_cfg.sv =====
// Configuration registers of the power fault qualifier.
module pfq_cfg
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_valid,
    input  logic                         cfg_ready,
    input  pfq_pkg::cfg_index_t          cfg_index,
    input  logic [pfq_pkg::DATA_W-1:0]   cfg_data,
    output pfq_pkg::cfg_t                cfg
);

    logic [pfq_pkg::THRESH_W-1:0] threshold_reg;
    logic [pfq_pkg::THRESH_W-1:0] threshold_next;
    logic [1:0]                   count_limit_reg;
    logic [1:0]                   count_limit_next;

    // Decode a write request into the addressed register.
    always_comb
    begin
        threshold_next   = threshold_reg;
        count_limit_next = count_limit_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                pfq_pkg::CFG_THRESHOLD:
                begin
                    threshold_next = cfg_data[pfq_pkg::THRESH_W-1:0];
                end
                pfq_pkg::CFG_COUNT_LIMIT:
                begin
                    count_limit_next = cfg_data[1:0];
                end
                default:
                begin
                    threshold_next = threshold_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg   <= pfq_pkg::ThresholdReset;
            count_limit_reg <= pfq_pkg::CountLimitReset;
        end
        else
        begin
            threshold_reg   <= threshold_next;
            count_limit_reg <= count_limit_next;
        end
    end

    assign cfg.threshold_ua = threshold_reg;
    assign cfg.count_limit  = count_limit_reg;

endmodule

// ===== src/pfq_judge.sv =====
// Check state and per-request decision logic of the power fault qualifier.
module pfq_judge
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             advance,
    input  pfq_pkg::item_t   item,
    input  pfq_pkg::cfg_t    cfg,
    output pfq_pkg::result_t result
);

    logic       sampling_reg;
    logic       sampling_next;
    logic [1:0] try_count_reg;
    logic [1:0] try_count_next;
    logic [1:0] over_count_reg;
    logic [1:0] over_count_next;

    logic [pfq_pkg::THRESH_W-1:0] current_ua;
    logic                         above_threshold;

    // Scale the sampled current to microamps; 65535 mA still fits in 26 bits.
    assign current_ua      = pfq_pkg::THRESH_W'(item.current_ma * pfq_pkg::MaToUa);
    assign above_threshold = current_ua > cfg.threshold_ua;

    // Judge one request against the current check state.
    always_comb
    begin
        sampling_next     = sampling_reg;
        try_count_next    = try_count_reg;
        over_count_next   = over_count_reg;
        result.verdict    = pfq_pkg::VERDICT_IGNORED;
        result.end_reason = pfq_pkg::REASON_NONE;

        case (item.kind)
            pfq_pkg::KIND_EVENT:
            begin
                // A new event always drops any running check.
                sampling_next   = 1'b0;
                try_count_next  = 2'd0;
                over_count_next = 2'd0;
                if (item.over_voltage)
                begin
                    result.verdict    = pfq_pkg::VERDICT_END_POWER;
                    result.end_reason = pfq_pkg::REASON_OVER_VOLTAGE;
                end
                else if (item.over_temperature)
                begin
                    result.verdict    = pfq_pkg::VERDICT_END_POWER;
                    result.end_reason = pfq_pkg::REASON_OVER_TEMPERATURE;
                end
                else if (item.under_voltage && !item.over_current)
                begin
                    result.verdict = pfq_pkg::VERDICT_IGNORED;
                end
                else
                begin
                    sampling_next  = 1'b1;
                    result.verdict = pfq_pkg::VERDICT_PENDING;
                end
            end
            pfq_pkg::KIND_SAMPLE:
            begin
                if (sampling_reg)
                begin
                    if (try_count_reg != pfq_pkg::TryCountMax)
                    begin
                        try_count_next = try_count_reg + 2'd1;
                    end
                    if (item.clear_ok && item.current_ok && above_threshold &&
                        over_count_reg != pfq_pkg::OverCountMax)
                    begin
                        over_count_next = over_count_reg + 2'd1;
                    end

                    // A readable status with over-current gone clears the check.
                    if (item.clear_ok && item.current_ok && item.status_ok &&
                        !item.still_over)
                    begin
                        sampling_next  = 1'b0;
                        result.verdict = pfq_pkg::VERDICT_TRANSIENT;
                    end
                    else if (try_count_next >= pfq_pkg::MaxTriesCode)
                    begin
                        sampling_next = 1'b0;
                        if (over_count_next < cfg.count_limit)
                        begin
                            result.verdict = pfq_pkg::VERDICT_TOO_FEW;
                        end
                        else
                        begin
                            result.verdict    = pfq_pkg::VERDICT_END_POWER;
                            result.end_reason = pfq_pkg::REASON_OVER_CURRENT;
                        end
                    end
                    else
                    begin
                        result.verdict = pfq_pkg::VERDICT_PENDING;
                    end
                end
            end
            default:
            begin
                result.verdict = pfq_pkg::VERDICT_IGNORED;
            end
        endcase

        result.over_samples = over_count_next;
        result.tries_used   = try_count_next;
    end

    // State moves only when the request passes on to the result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sampling_reg   <= 1'b0;
            try_count_reg  <= 2'd0;
            over_count_reg <= 2'd0;
        end
        else if (advance)
        begin
            sampling_reg   <= sampling_next;
            try_count_reg  <= try_count_next;
            over_count_reg <= over_count_next;
        end
    end

    // A running check never sits at its last try.
    assert property (@(posedge clk) disable iff (!rst_n)
        sampling_reg |-> (try_count_reg < pfq_pkg::MaxTriesCode))
        else $error("check still running after its last try");

    // A sample while idle leaves the counts of the last check untouched.
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && item.kind == pfq_pkg::KIND_SAMPLE && !sampling_reg) |=>
        ($stable(try_count_reg) && $stable(over_count_reg) && !sampling_reg))
        else $error("idle sample changed the check state");

    // Every event restarts the counts.
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && item.kind == pfq_pkg::KIND_EVENT) |=>
        (try_count_reg == 2'd0 && over_count_reg == 2'd0))
        else $error("event did not restart the counts");

    // Ending power always carries a reason, and only then.
    assert property (@(posedge clk) disable iff (!rst_n)
        advance |-> ((result.verdict == pfq_pkg::VERDICT_END_POWER) ==
                     (result.end_reason != pfq_pkg::REASON_NONE)))
        else $error("end reason does not match verdict");

endmodule

// ===== src/power_fault_qualifier_top.sv =====
// Top level of the power fault qualifier: input register, decision logic, result register.
//
// The block judges limit status events and poll samples of a wireless power receiver and
// gives exactly one result per request. A request passes an input register, then the
// decision logic (one 16 by 10 bit multiply and a 26-bit compare) into the result
// register, and a new request is taken every cycle as long as the output side keeps up.
// While a finished result still waits to be taken, a request held in the input register
// stalls the input side. Configuration is always ready and must be written only while
// no request is in flight.
module power_fault_qualifier_top
(
    input  logic                          clk,
    input  logic                          rst_n,

    // Request channel.
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          kind,
    input  logic                          over_voltage,
    input  logic                          over_temperature,
    input  logic                          under_voltage,
    input  logic                          over_current,
    input  logic                          clear_ok,
    input  logic                          current_ok,
    input  logic [pfq_pkg::MA_W-1:0]      current_ma,
    input  logic                          status_ok,
    input  logic                          still_over,

    // Result channel.
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [2:0]                    verdict,
    output logic [1:0]                    end_reason,
    output logic [1:0]                    over_samples,
    output logic [1:0]                    tries_used,

    // Configuration write channel.
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic                          cfg_index,
    input  logic [pfq_pkg::DATA_W-1:0]    cfg_data
);

    pfq_pkg::cfg_t    cfg;
    pfq_pkg::item_t   item_in;
    pfq_pkg::item_t   item_reg;
    pfq_pkg::result_t result;
    pfq_pkg::result_t result_reg;

    logic in_valid_reg;
    logic in_valid_next;
    logic out_valid_reg;
    logic out_valid_next;
    logic out_free;
    logic advance;
    logic accept_in;

    assign cfg_ready = 1'b1;

    pfq_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (pfq_pkg::cfg_index_t'(cfg_index)),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Gather the request fields.
    assign item_in.kind             = pfq_pkg::kind_t'(kind);
    assign item_in.over_voltage     = over_voltage;
    assign item_in.over_temperature = over_temperature;
    assign item_in.under_voltage    = under_voltage;
    assign item_in.over_current     = over_current;
    assign item_in.clear_ok         = clear_ok;
    assign item_in.current_ok       = current_ok;
    assign item_in.current_ma       = current_ma;
    assign item_in.status_ok        = status_ok;
    assign item_in.still_over       = still_over;

    // Handshake: the result register is free when empty or being taken.
    assign out_free  = !out_valid_reg || !out_stall;
    assign advance   = in_valid_reg && out_free;
    assign in_stall  = in_valid_reg && !out_free;
    assign accept_in = in_valid && !in_stall;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (accept_in)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers load on their handshakes and need no reset.
    always_ff @(posedge clk)
    begin
        if (accept_in)
        begin
            item_reg <= item_in;
        end
        if (advance)
        begin
            result_reg <= result;
        end
    end

    pfq_judge u_judge
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (item_reg),
        .cfg     (cfg),
        .result  (result)
    );

    assign out_valid    = out_valid_reg;
    assign verdict      = result_reg.verdict;
    assign end_reason   = result_reg.end_reason;
    assign over_samples = result_reg.over_samples;
    assign tries_used   = result_reg.tries_used;

endmodule

// ===== tb/power_fault_qualifier_top_test.sv =====
// Self-checking testbench of the power fault qualifier with its own prediction of every result.
module power_fault_qualifier_top_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT = 400000;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;

    logic                         in_valid = 1'b0;
    logic                         in_stall;
    logic                         kind = 1'b0;
    logic                         over_voltage = 1'b0;
    logic                         over_temperature = 1'b0;
    logic                         under_voltage = 1'b0;
    logic                         over_current = 1'b0;
    logic                         clear_ok = 1'b0;
    logic                         current_ok = 1'b0;
    logic [pfq_pkg::MA_W-1:0]     current_ma = '0;
    logic                         status_ok = 1'b0;
    logic                         still_over = 1'b0;

    logic                         out_valid;
    logic                         out_stall = 1'b0;
    logic [2:0]                   verdict;
    logic [1:0]                   end_reason;
    logic [1:0]                   over_samples;
    logic [1:0]                   tries_used;

    logic                         cfg_valid = 1'b0;
    logic                         cfg_ready;
    logic                         cfg_index = 1'b0;
    logic [pfq_pkg::DATA_W-1:0]   cfg_data = '0;

    // Requests waiting to be sent and results still owed by the block.
    pfq_pkg::item_t               pending_reqs[$];
    pfq_pkg::result_t             expected_results[$];
    pfq_pkg::item_t               cur_req;

    // Predicted configuration and check state.
    logic [pfq_pkg::THRESH_W-1:0] thresh_ua = pfq_pkg::ThresholdReset;
    logic [1:0]                   over_limit = pfq_pkg::CountLimitReset;
    logic                         chk_active = 1'b0;
    logic [1:0]                   chk_tries = '0;
    logic [1:0]                   chk_overs = '0;

    // Idle pacing of both sides, in percent chance per cycle of starting a burst.
    int                           gap_pct = 0;
    int                           stall_pct = 0;
    int                           gap_left = 0;
    int                           stall_left = 0;

    int                           err_count = 0;
    int unsigned                  cycle_count = 0;

    power_fault_qualifier_top u_top (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Works out the result of one request and advances the predicted check state.
    function automatic pfq_pkg::result_t judge_request(input pfq_pkg::item_t r);
        pfq_pkg::result_t res;
        logic [31:0]      load_ua;
        logic             done;
        res.verdict = pfq_pkg::VERDICT_PENDING;
        res.end_reason = pfq_pkg::REASON_NONE;
        load_ua = 32'(r.current_ma) * 32'(pfq_pkg::MaToUa);
        done = 1'b0;
        if (r.kind == pfq_pkg::KIND_EVENT)
        begin
            chk_active = 1'b0;
            chk_tries = '0;
            chk_overs = '0;
            if (r.over_voltage)
            begin
                res.verdict = pfq_pkg::VERDICT_END_POWER;
                res.end_reason = pfq_pkg::REASON_OVER_VOLTAGE;
            end
            else if (r.over_temperature)
            begin
                res.verdict = pfq_pkg::VERDICT_END_POWER;
                res.end_reason = pfq_pkg::REASON_OVER_TEMPERATURE;
            end
            else if (r.under_voltage && !r.over_current)
                res.verdict = pfq_pkg::VERDICT_IGNORED;
            else
                chk_active = 1'b1;
        end
        else if (!chk_active)
            res.verdict = pfq_pkg::VERDICT_IGNORED;
        else
        begin
            if (chk_tries < pfq_pkg::TryCountMax)
                chk_tries = chk_tries + 2'd1;
            if (r.clear_ok && r.current_ok)
            begin
                if (load_ua > 32'(thresh_ua) && chk_overs < pfq_pkg::OverCountMax)
                    chk_overs = chk_overs + 2'd1;
                if (r.status_ok && !r.still_over)
                begin
                    chk_active = 1'b0;
                    res.verdict = pfq_pkg::VERDICT_TRANSIENT;
                    done = 1'b1;
                end
            end
            if (!done && chk_tries >= pfq_pkg::MaxTriesCode)
            begin
                chk_active = 1'b0;
                if (chk_overs < over_limit)
                    res.verdict = pfq_pkg::VERDICT_TOO_FEW;
                else
                begin
                    res.verdict = pfq_pkg::VERDICT_END_POWER;
                    res.end_reason = pfq_pkg::REASON_OVER_CURRENT;
                end
            end
        end
        res.over_samples = chk_overs;
        res.tries_used = chk_tries;
        return res;
    endfunction

    // Random request of the given kind; fields that the kind ignores stay random.
    function automatic pfq_pkg::item_t make_item(input pfq_pkg::kind_t k);
        pfq_pkg::item_t r;
        logic [31:0]    bits;
        int             pick;
        int             ma;
        bits = $urandom;
        r = bits[$bits(pfq_pkg::item_t)-1:0];
        r.kind = k;
        pick = $urandom_range(0, 99);
        if (k == pfq_pkg::KIND_EVENT)
        begin
            // Mostly events that open a check, the rest end power or are ignored.
            if (pick < 10)
                r.over_voltage = 1'b1;
            else if (pick < 20)
            begin
                r.over_voltage = 1'b0;
                r.over_temperature = 1'b1;
            end
            else if (pick < 30)
            begin
                r.over_voltage = 1'b0;
                r.over_temperature = 1'b0;
                r.under_voltage = 1'b1;
                r.over_current = 1'b0;
            end
            else
            begin
                r.over_voltage = 1'b0;
                r.over_temperature = 1'b0;
                if (r.under_voltage)
                    r.over_current = 1'b1;
            end
        end
        else
        begin
            r.clear_ok = ($urandom_range(0, 99) < 88);
            r.current_ok = ($urandom_range(0, 99) < 88);
            r.status_ok = ($urandom_range(0, 99) < 80);
            r.still_over = ($urandom_range(0, 99) < 65);
            // Currents cluster around the threshold and at the ends of the range.
            if (pick < 40)
            begin
                ma = int'(thresh_ua) / 1000 + int'($urandom_range(0, 2)) - 1;
                if (ma < 0)
                    ma = 0;
                if (ma > 65535)
                    ma = 65535;
                r.current_ma = 16'(ma);
            end
            else if (pick < 50)
                r.current_ma = ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
        end
        return r;
    endfunction

    function automatic pfq_pkg::item_t status_event(input logic ov, input logic ot,
                                                    input logic uv, input logic oc);
        pfq_pkg::item_t r;
        r = make_item(pfq_pkg::KIND_EVENT);
        r.over_voltage = ov;
        r.over_temperature = ot;
        r.under_voltage = uv;
        r.over_current = oc;
        return r;
    endfunction

    function automatic pfq_pkg::item_t poll_sample(input logic clr, input logic cur,
                                                   input logic [pfq_pkg::MA_W-1:0] ma,
                                                   input logic st, input logic still);
        pfq_pkg::item_t r;
        r = make_item(pfq_pkg::KIND_SAMPLE);
        r.clear_ok = clr;
        r.current_ok = cur;
        r.current_ma = ma;
        r.status_ok = st;
        r.still_over = still;
        return r;
    endfunction

    // Queues checks: an event followed by a few samples, with some loose noise requests.
    task automatic queue_checks(input int count);
        int             made;
        int             n_samples;
        logic [31:0]    bits;
        pfq_pkg::item_t r;
        made = 0;
        while (made < count)
        begin
            if ($urandom_range(0, 99) < 8)
            begin
                bits = $urandom;
                r = bits[$bits(pfq_pkg::item_t)-1:0];
                pending_reqs.push_back(r);
                made++;
            end
            else
            begin
                pending_reqs.push_back(make_item(pfq_pkg::KIND_EVENT));
                made++;
                n_samples = $urandom_range(0, 4);
                repeat (n_samples)
                begin
                    pending_reqs.push_back(make_item(pfq_pkg::KIND_SAMPLE));
                    made++;
                end
            end
        end
    endtask

    task automatic write_reg(input pfq_pkg::cfg_index_t idx,
                             input logic [pfq_pkg::DATA_W-1:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == pfq_pkg::CFG_THRESHOLD)
            thresh_ua = data[pfq_pkg::THRESH_W-1:0];
        else
            over_limit = data[1:0];
    endtask

    // Waits until every request is sent and answered, then lets the pipeline settle.
    task automatic wait_drained;
        while (pending_reqs.size() != 0 || expected_results.size() != 0 || in_valid)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Request driver.
    always @(posedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && !in_stall)
                expected_results.push_back(judge_request(cur_req));
            if (!in_valid || !in_stall)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (pending_reqs.size() != 0)
                begin
                    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct)
                    begin
                        gap_left = $urandom_range(1, 17) - 1;
                        in_valid <= 1'b0;
                    end
                    else
                    begin
                        cur_req = pending_reqs.pop_front();
                        kind <= cur_req.kind;
                        over_voltage <= cur_req.over_voltage;
                        over_temperature <= cur_req.over_temperature;
                        under_voltage <= cur_req.under_voltage;
                        over_current <= cur_req.over_current;
                        clear_ok <= cur_req.clear_ok;
                        current_ok <= cur_req.current_ok;
                        current_ma <= cur_req.current_ma;
                        status_ok <= cur_req.status_ok;
                        still_over <= cur_req.still_over;
                        in_valid <= 1'b1;
                    end
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Result monitor and output stall.
    always @(posedge clk)
    begin
        pfq_pkg::result_t want;
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    err_count++;
                    if (err_count <= 10)
                        $display("Unexpected result: verdict %0d reason %0d overs %0d tries %0d",
                                 verdict, end_reason, over_samples, tries_used);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (verdict !== want.verdict || end_reason !== want.end_reason ||
                        over_samples !== want.over_samples || tries_used !== want.tries_used)
                    begin
                        err_count++;
                        if (err_count <= 10)
                            $display({"Result mismatch: expected verdict %0d reason %0d ",
                                      "overs %0d tries %0d, got %0d %0d %0d %0d"},
                                     want.verdict, want.end_reason, want.over_samples,
                                     want.tries_used, verdict, end_reason, over_samples,
                                     tries_used);
                    end
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct)
            begin
                stall_left = $urandom_range(1, 17) - 1;
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Reset, directed checks, then random phases over several settings.
    initial
    begin
        logic [pfq_pkg::DATA_W-1:0] thr;
        logic [1:0]                 lim;
        logic [31:0]                upper;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part under the reset settings.
        gap_pct = 6;
        stall_pct = 6;
        pending_reqs.push_back(poll_sample(1'b1, 1'b1, 16'd2000, 1'b0, 1'b1));
        pending_reqs.push_back(status_event(1'b1, 1'b1, 1'b1, 1'b1));
        pending_reqs.push_back(status_event(1'b0, 1'b1, 1'b1, 1'b1));
        pending_reqs.push_back(status_event(1'b0, 1'b0, 1'b1, 1'b0));
        // Under-voltage with over-current opens a check; failed clear, failed read.
        pending_reqs.push_back(status_event(1'b0, 1'b0, 1'b1, 1'b1));
        pending_reqs.push_back(poll_sample(1'b0, 1'b1, 16'd3000, 1'b1, 1'b0));
        pending_reqs.push_back(poll_sample(1'b1, 1'b0, 16'd3000, 1'b1, 1'b0));
        pending_reqs.push_back(poll_sample(1'b1, 1'b1, 16'd1401, 1'b0, 1'b0));
        // A sample after the check has ended keeps the last counts.
        pending_reqs.push_back(poll_sample(1'b1, 1'b1, 16'd1401, 1'b1, 1'b1));
        // Exactly at the threshold is not over; over-current gone ends as transient.
        pending_reqs.push_back(status_event(1'b0, 1'b0, 1'b0, 1'b0));
        pending_reqs.push_back(poll_sample(1'b1, 1'b1, 16'd1400, 1'b1, 1'b0));
        // A new event in the middle of a check restarts it.
        pending_reqs.push_back(status_event(1'b0, 1'b0, 1'b0, 1'b1));
        pending_reqs.push_back(poll_sample(1'b1, 1'b1, 16'hFFFF, 1'b1, 1'b1));
        pending_reqs.push_back(status_event(1'b0, 1'b0, 1'b0, 1'b1));
        pending_reqs.push_back(poll_sample(1'b1, 1'b1, 16'd0, 1'b1, 1'b1));
        pending_reqs.push_back(poll_sample(1'b1, 1'b1, 16'd0, 1'b0, 1'b1));
        pending_reqs.push_back(poll_sample(1'b1, 1'b1, 16'd0, 1'b1, 1'b1));
        // Three over samples in a row end power.
        pending_reqs.push_back(status_event(1'b0, 1'b0, 1'b0, 1'b1));
        pending_reqs.push_back(poll_sample(1'b1, 1'b1, 16'hFFFF, 1'b1, 1'b1));
        pending_reqs.push_back(poll_sample(1'b1, 1'b1, 16'hFFFF, 1'b0, 1'b0));
        pending_reqs.push_back(poll_sample(1'b1, 1'b1, 16'hFFFF, 1'b1, 1'b1));
        wait_drained();

        // Random phases; the extremes come first, the last phase runs without idling.
        for (int p = 0; p < 7; p++)
        begin
            upper = $urandom;
            case (p)
                0:
                begin
                    thr = '0;
                    lim = 2'd0;
                end
                1:
                begin
                    thr = pfq_pkg::DATA_W'(65535000);
                    lim = 2'd3;
                end
                2:
                begin
                    thr = pfq_pkg::DATA_W'(pfq_pkg::ThresholdReset);
                    lim = 2'd2;
                end
                6:
                begin
                    thr = pfq_pkg::DATA_W'(pfq_pkg::ThresholdReset);
                    lim = pfq_pkg::CountLimitReset;
                end
                default:
                begin
                    thr = pfq_pkg::DATA_W'($urandom_range(0, 65535000));
                    lim = 2'($urandom_range(0, 3));
                end
            endcase
            write_reg(pfq_pkg::CFG_THRESHOLD, thr);
            write_reg(pfq_pkg::CFG_COUNT_LIMIT, {upper[pfq_pkg::DATA_W-3:0], lim});
            gap_pct = (p == 1 || p == 6) ? 0 : 5 + p;
            stall_pct = (p == 1 || p == 6) ? 0 : 10 - p;
            queue_checks(260);
            wait_drained();
        end

        repeat (8) @(posedge clk);
        if (err_count == 0 && expected_results.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
